// ===== rtl/tmq_pkg.sv =====
// tmq_pkg: shared types and codes for the timed message queue.
// Holds request/result structs, request and result kind codes, default depth.
// No dependencies.
package tmq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [1:0] REQ_SCHED_GAME = 2'd0;
  localparam logic [1:0] REQ_SCHED_SYS  = 2'd1;
  localparam logic [1:0] REQ_UPDATE     = 2'd2;
  localparam logic [1:0] REQ_CLEAR      = 2'd3;

  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_DROPPED  = 2'd1;
  localparam logic [1:0] KIND_DELIVERY = 2'd2;
  localparam logic [1:0] KIND_IDLE     = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] delay_ms;
    logic [31:0] target_id;
    logic [15:0] message_handle;
    logic [31:0] game_tick;
    logic [31:0] sys_tick;
  } tmq_req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] out_target;
    logic [15:0] out_handle;
    logic        last_result;
  } tmq_res_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic        base;
    logic [31:0] target;
    logic [15:0] handle;
  } tmq_entry_t;

endpackage

// ===== rtl/timed_message_queue.sv =====
// timed_message_queue: top level of the timed message queue.
// Depends on tmq_pkg and tmq_alu; entry storage is a local memory.
//
// An item is taken when start is high and busy is low. Schedule and clear
// items give one result, which shows in the cycle busy drops. An update
// walks the stored entries one per cycle through a single adder and a
// one-read, one-write memory, so busy stays high through the whole walk;
// deliveries appear one per strobe as they are found, the last one marked,
// and the final result shows in the cycle busy drops. Results are held for
// a single cycle and the receiver cannot stall them.
module timed_message_queue #(
  parameter int QUEUE_DEPTH = tmq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tmq_pkg::tmq_req_t  req,
  output logic               strobe,
  output tmq_pkg::tmq_res_t  result
);
  import tmq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t     state;
  tmq_req_t   cur;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] keep;
  logic [CNT_W-1:0] idx_inc;
  logic             pend_valid;
  logic [31:0]      pend_target;
  logic [15:0]      pend_handle;

  tmq_entry_t mem [QUEUE_DEPTH];
  tmq_entry_t rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  tmq_entry_t       wr_data;

  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic        alu_sub;
  logic [31:0] alu_sum;
  logic        alu_lt;
  logic        is_sched;
  logic        full;

  assign busy     = (state != S_IDLE);
  assign idx_inc  = idx + 1'b1;
  assign is_sched = cur.req_type inside {REQ_SCHED_GAME, REQ_SCHED_SYS};
  assign full     = (count >= CNT_W'(QUEUE_DEPTH));

  always_comb begin
    alu_sub = (state == S_SCAN);
    if (state == S_SCAN) begin
      alu_a = rd_data.deadline;
      alu_b = rd_data.base ? cur.sys_tick : cur.game_tick;
    end else begin
      alu_a = (cur.req_type == REQ_SCHED_SYS) ? cur.sys_tick : cur.game_tick;
      alu_b = cur.delay_ms;
    end
  end

  tmq_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .op_sub (alu_sub),
    .sum    (alu_sum),
    .lt     (alu_lt)
  );

  always_comb begin
    rd_addr = (state == S_SCAN) ? idx_inc[IDX_W-1:0] : '0;
    wr_en   = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_data = '{deadline: alu_sum, base: cur.req_type[0],
                target: cur.target_id, handle: cur.message_handle};
    if (state == S_EXEC && is_sched && !full) begin
      wr_en = 1'b1;
    end else if (state == S_SCAN && !alu_lt) begin
      wr_en   = 1'b1;
      wr_addr = keep[IDX_W-1:0];
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
      idx        <= '0;
      keep       <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur   <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          idx        <= '0;
          keep       <= '0;
          pend_valid <= 1'b0;
          if (is_sched) begin
            strobe <= 1'b1;
            state  <= S_IDLE;
            result <= '{result_kind: full ? KIND_DROPPED : KIND_ACCEPTED,
                        out_target: '0, out_handle: '0, last_result: 1'b1};
            if (!full) begin
              count <= count + 1'b1;
            end
          end else if (cur.req_type == REQ_CLEAR) begin
            strobe <= 1'b1;
            count  <= '0;
            state  <= S_IDLE;
            result <= '{result_kind: KIND_IDLE, out_target: '0,
                        out_handle: '0, last_result: 1'b1};
          end else if (count == '0) begin
            state <= S_FIN;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (alu_lt) begin
            if (pend_valid) begin
              strobe <= 1'b1;
              result <= '{result_kind: KIND_DELIVERY, out_target: pend_target,
                          out_handle: pend_handle, last_result: 1'b0};
            end
            pend_valid  <= 1'b1;
            pend_target <= rd_data.target;
            pend_handle <= rd_data.handle;
          end else begin
            keep <= keep + 1'b1;
          end
          idx <= idx_inc;
          if (idx_inc == count) begin
            count <= alu_lt ? keep : keep + 1'b1;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          strobe <= 1'b1;
          state  <= S_IDLE;
          if (pend_valid) begin
            result <= '{result_kind: KIND_DELIVERY, out_target: pend_target,
                        out_handle: pend_handle, last_result: 1'b1};
          end else begin
            result <= '{result_kind: KIND_IDLE, out_target: '0,
                        out_handle: '0, last_result: 1'b1};
          end
          pend_valid <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/tmq_alu.sv =====
// tmq_alu: shared 32-bit adder used for deadline sums and deadline compares.
// Subtract mode reports an unsigned a < b through the borrow.
// No dependencies.
module tmq_alu (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        op_sub,
  output logic [31:0] sum,
  output logic        lt
);

  logic [31:0] b_eff;
  logic [32:0] res;

  assign b_eff = op_sub ? ~b : b;
  assign res   = {1'b0, a} + {1'b0, b_eff} + {32'd0, op_sub};
  assign sum   = res[31:0];
  assign lt    = op_sub & ~res[32];

endmodule

// ===== rtl/tmq_checker.sv =====
// tmq_checker: port-level assertions for the timed message queue.
// Depends on tmq_pkg; bound to timed_message_queue at the end of this file.
module tmq_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input tmq_pkg::tmq_res_t result
);
  import tmq_pkg::*;

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.result_kind != KIND_DELIVERY) |-> result.last_result)
    else $error("non-delivery result not marked last");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.result_kind != KIND_DELIVERY)
      |-> (result.out_target == '0) && (result.out_handle == '0))
    else $error("non-delivery result carries payload");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_result |-> !busy)
    else $error("last result shown while still busy");

endmodule

bind timed_message_queue tmq_checker u_tmq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

// ===== tb/timed_message_queue_checker.sv =====
`timescale 1ns / 1ps
// Checker for the timed message queue: keeps its own copy of the queued
// messages, predicts the result items of every accepted request and compares
// them with the strobed results. Depends on tmq_pkg.
module timed_message_queue_checker
  import tmq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  tmq_req_t req,
  input  logic     strobe,
  input  tmq_res_t result,
  output int       errors,
  output int       pending,
  output int       deliveries,
  output int       drops
);

  tmq_entry_t  held [QUEUE_DEPTH];
  int unsigned held_count;
  tmq_res_t    awaited_q [$];
  tmq_res_t    want;

  function automatic void expect_result(logic [1:0] kind, logic [31:0] tgt,
                                        logic [15:0] hnd, logic last);
    tmq_res_t r;
    r.result_kind = kind;
    r.out_target  = tgt;
    r.out_handle  = hnd;
    r.last_result = last;
    awaited_q = {awaited_q, r};
  endfunction

  function automatic void predict_request(tmq_req_t r);
    logic [31:0] now;
    logic [31:0] deadline;
    int unsigned keep;
    tmq_res_t    prev;
    bit          have_prev;
    keep = 0;
    have_prev = 0;
    case (r.req_type)
      REQ_SCHED_GAME, REQ_SCHED_SYS: begin
        if (held_count >= QUEUE_DEPTH) begin
          expect_result(KIND_DROPPED, '0, '0, 1'b1);
        end else begin
          now = (r.req_type == REQ_SCHED_SYS) ? r.sys_tick : r.game_tick;
          deadline = now + r.delay_ms;
          held[held_count].deadline = deadline;
          held[held_count].base     = (r.req_type == REQ_SCHED_SYS);
          held[held_count].target   = r.target_id;
          held[held_count].handle   = r.message_handle;
          held_count++;
          expect_result(KIND_ACCEPTED, '0, '0, 1'b1);
        end
      end
      REQ_CLEAR: begin
        held_count = 0;
        expect_result(KIND_IDLE, '0, '0, 1'b1);
      end
      default: begin
        for (int i = 0; i < held_count; i++) begin
          now = held[i].base ? r.sys_tick : r.game_tick;
          if (held[i].deadline < now) begin
            if (have_prev) awaited_q = {awaited_q, prev};
            prev.result_kind = KIND_DELIVERY;
            prev.out_target  = held[i].target;
            prev.out_handle  = held[i].handle;
            prev.last_result = 1'b0;
            have_prev = 1;
          end else begin
            held[keep] = held[i];
            keep++;
          end
        end
        held_count = keep;
        if (have_prev) begin
          prev.last_result = 1'b1;
          awaited_q = {awaited_q, prev};
        end else begin
          expect_result(KIND_IDLE, '0, '0, 1'b1);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      awaited_q.delete();
      errors = 0;
      deliveries = 0;
      drops = 0;
      pending <= 0;
    end else begin
      if (strobe) begin
        if (awaited_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind=%0d target=%h handle=%h last=%b",
                   $time, result.result_kind, result.out_target,
                   result.out_handle, result.last_result);
        end else begin
          want = awaited_q.pop_front();
          if (result.result_kind !== want.result_kind ||
              result.out_target !== want.out_target ||
              result.out_handle !== want.out_handle ||
              result.last_result !== want.last_result) begin
            errors++;
            $display("%0t: mismatch expected kind=%0d target=%h handle=%h last=%b",
                     $time, want.result_kind, want.out_target, want.out_handle,
                     want.last_result);
            $display("%0t:          actual   kind=%0d target=%h handle=%h last=%b",
                     $time, result.result_kind, result.out_target,
                     result.out_handle, result.last_result);
          end
          if (want.result_kind == KIND_DELIVERY) deliveries++;
          if (want.result_kind == KIND_DROPPED) drops++;
        end
      end
      if (start && !busy) predict_request(req);
      pending <= awaited_q.size();
    end
  end

endmodule

// ===== tb/timed_message_queue_test.sv =====
`timescale 1ns / 1ps
// Top of the timed message queue testbench: clock, reset, request stimulus
// with random sender gaps, watchdog and verdict. Depends on tmq_pkg, the
// timed_message_queue block and timed_message_queue_checker.
module timed_message_queue_test;
  import tmq_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 129;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  tmq_req_t req = '0;
  logic     busy;
  logic     strobe;
  tmq_res_t result;

  int          errors;
  int          pending;
  int          deliveries;
  int          drops;
  int          idle_pct = 0;
  int          sched_pct = 50;
  int          sent = 0;
  int          stall_cycles = 0;
  logic [31:0] game_now = '0;
  logic [31:0] sys_now = '0;

  always #2 clk = ~clk;

  timed_message_queue u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .strobe(strobe),
    .result(result)
  );

  timed_message_queue_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .strobe    (strobe),
    .result    (result),
    .errors    (errors),
    .pending   (pending),
    .deliveries(deliveries),
    .drops     (drops)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic tmq_req_t make_req(logic [1:0] kind, logic [31:0] delay,
                                        logic [31:0] tgt, logic [15:0] hnd,
                                        logic [31:0] gtime, logic [31:0] stime);
    tmq_req_t r;
    r.req_type       = kind;
    r.delay_ms       = delay;
    r.target_id      = tgt;
    r.message_handle = hnd;
    r.game_tick      = gtime;
    r.sys_tick       = stime;
    return r;
  endfunction

  // Mostly coherent traffic on two advancing clocks; some fully random noise.
  function automatic tmq_req_t rand_req();
    tmq_req_t    r;
    int unsigned pick;
    r = make_req(2'($urandom_range(0, 3)), $urandom, $urandom,
                 16'($urandom_range(0, 65535)), $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick >= 8) begin
      game_now = game_now + $urandom_range(0, 10);
      sys_now  = sys_now + $urandom_range(0, 10);
      r.game_tick = game_now;
      r.sys_tick  = sys_now;
      pick = $urandom_range(0, 99);
      if (pick < sched_pct) begin
        r.req_type = $urandom_range(0, 1) ? REQ_SCHED_SYS : REQ_SCHED_GAME;
        if ($urandom_range(0, 9) != 0) r.delay_ms = $urandom_range(0, 80);
      end else if (pick < 97) begin
        r.req_type = REQ_UPDATE;
      end else begin
        r.req_type = REQ_CLEAR;
      end
    end
    return r;
  endfunction

  // Enter and leave in the time step of a rising edge.
  task automatic send(tmq_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(make_req(REQ_UPDATE, '0, '0, '0, '0, '0));
    send(make_req(REQ_CLEAR, '1, '1, '1, '1, '1));
    send(make_req(REQ_SCHED_GAME, '0, '1, 16'hFFFF, '0, '1));
    send(make_req(REQ_SCHED_SYS, '1, '0, '0, '1, 32'd1));
    send(make_req(REQ_UPDATE, '0, '0, '0, '0, '0));
    send(make_req(REQ_UPDATE, '0, '0, '0, 32'd1, '0));
    send(make_req(REQ_UPDATE, '0, '0, '0, '0, 32'd1));
    for (int i = 0; i < 15; i++) begin
      send(make_req((i % 2) ? REQ_SCHED_SYS : REQ_SCHED_GAME, 32'(i * 4),
                    32'hA5A5_0000 + 32'(i), 16'(~i), 32'd100, 32'd100));
    end
    send(make_req(REQ_SCHED_SYS, '0, 32'h0000_FFFF, 16'h5A5A, '0, '1));
    send(make_req(REQ_SCHED_GAME, 32'd1, 32'h1234_5678, 16'h1234, '0, '0));
    send(make_req(REQ_UPDATE, '0, '0, '0, 32'd130, '0));
    send(make_req(REQ_CLEAR, '0, '0, '0, '0, '0));
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 56 : 33;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 16 == 0) begin
          case ($urandom_range(0, 2))
            0: sched_pct = 85;
            1: sched_pct = 50;
            default: sched_pct = 25;
          endcase
          if ($urandom_range(0, 5) == 0) begin
            game_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
            sys_now  = 32'hFFFF_FFFF - $urandom_range(0, 200);
          end
        end
        send(rand_req());
      end
      drain();
    end

    repeat (24) @(posedge clk);
    $display("Covered %0d requests over directed, back-to-back and gapped phases;",
             sent);
    $display("%0d deliveries and %0d dropped schedules were checked.",
             deliveries, drops);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
